>>> hdl/sbu_pkg.sv
// shared types, constants and arithmetic helpers for the separable blend unit
`default_nettype none
package sbu_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam int CH_W = CHANNEL_BITS;

    typedef logic [CH_W-1:0]   ch_t;
    typedef logic [2*CH_W+1:0] wide_t;
    typedef logic [CH_W+1:0]   quo_t;

    localparam ch_t CH_MAX = '1;

    // two restoring steps per divider stage, at least six stages so soft light fits
    localparam int DIV_STEPS  = 2;
    localparam int DIV_RAW    = (CH_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_STAGES = (DIV_RAW > 6) ? DIV_RAW : 6;
    localparam int SOFT_HOLD  = DIV_STAGES - 5;
    localparam int LANE_LAT   = DIV_STAGES + 4;

    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_MULTIPLY   = 4'd1,
        MODE_SCREEN     = 4'd2,
        MODE_OVERLAY    = 4'd3,
        MODE_DARKEN     = 4'd4,
        MODE_LIGHTEN    = 4'd5,
        MODE_DODGE      = 4'd6,
        MODE_BURN       = 4'd7,
        MODE_LIN_DODGE  = 4'd8,
        MODE_LIN_BURN   = 4'd9,
        MODE_HARD_LIGHT = 4'd10,
        MODE_SOFT_LIGHT = 4'd11,
        MODE_DIFFERENCE = 4'd12,
        MODE_EXCLUSION  = 4'd13
    } mode_t;

    typedef enum logic [1:0] {
        SEL_FIXED,
        SEL_QUOT,
        SEL_INV_QUOT,
        SEL_SOFT
    } sel_t;

    typedef struct packed {
        logic [3:0] func;
        ch_t        fg;
        ch_t        bg;
    } lane_in_t;

    typedef struct packed {
        ch_t r;
        ch_t lo;
        ch_t q;
        ch_t d;
    } div_st_t;

    function automatic wide_t wz(input ch_t v);
        return {{(CH_W+2){1'b0}}, v};
    endfunction

    // floor(x / CH_MAX) by folding the high part back onto the low part
    function automatic quo_t div_m(input wide_t x);
        quo_t          q0;
        ch_t           lo;
        logic [CH_W+2:0] t;
        logic [2:0]    t1;
        logic [CH_W:0] t2;
        begin
            q0 = x[2*CH_W+1:CH_W];
            lo = x[CH_W-1:0];
            t  = {1'b0, q0} + {3'b0, lo};
            t1 = t[CH_W+2:CH_W];
            t2 = {1'b0, t[CH_W-1:0]} + {{(CH_W-2){1'b0}}, t1};
            return q0 + {{(CH_W-1){1'b0}}, t1}
                + {{(CH_W+1){1'b0}}, (t2 >= {1'b0, CH_MAX})};
        end
    endfunction

    function automatic ch_t clamp_ch(input logic signed [CH_W+3:0] v);
        begin
            if (v < 0)
                return '0;
            else if (v > $signed({4'b0, CH_MAX}))
                return CH_MAX;
            else
                return v[CH_W-1:0];
        end
    endfunction

    // a + b - ceil(p / CH_MAX), p being the product of a and b
    function automatic ch_t screen_ch(input ch_t a, input ch_t b, input wide_t p);
        quo_t cq;
        logic signed [CH_W+3:0] v;
        begin
            cq = div_m(p + wz(CH_MAX) - wide_t'(1));
            v  = $signed({4'b0, a}) + $signed({4'b0, b}) - $signed({2'b0, cq});
            return clamp_ch(v);
        end
    endfunction

    function automatic div_st_t div_step(input div_st_t s);
        logic [CH_W:0] rx;
        logic [CH_W:0] diff;
        logic          ge;
        div_st_t       o;
        begin
            o    = s;
            rx   = {s.r, s.lo[CH_W-1]};
            diff = rx - {1'b0, s.d};
            ge   = (rx >= {1'b0, s.d});
            o.r  = ge ? diff[CH_W-1:0] : rx[CH_W-1:0];
            o.lo = {s.lo[CH_W-2:0], 1'b0};
            o.q  = {s.q[CH_W-2:0], ge};
            return o;
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/sbu_lane.sv
// one color channel blend pipeline: products, constant divides, shared quotient divider
`default_nettype none
module sbu_lane
    import sbu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     en,
    input  wire lane_in_t lane_in,
    output ch_t           res
);

    // stage 1: captured operands
    logic [3:0] mode1_reg;
    ch_t        a1_reg, b1_reg;

    // stage 2
    logic [3:0] mode2_reg;
    ch_t        a2_reg, b2_reg;
    wide_t      ab2_reg, hlp2_reg, ovp2_reg, p1_2_reg, p2_2_reg;
    logic       hl_lo2_reg, ov_lo2_reg;
    ch_t        hl_x2_reg, ov_x2_reg;
    logic [2*CH_W-1:0] dn2_reg;
    ch_t        dd2_reg;
    logic       ovr2_reg;
    ch_t        simp2_reg;

    // stage 3
    ch_t        res3_reg;
    sel_t       sel3_reg;
    wide_t      s3_reg;
    ch_t        b3_reg;
    div_st_t    dinit3_reg;

    // soft light chain
    quo_t       qs4_reg;
    wide_t      s4_reg;
    ch_t        b4_reg;
    quo_t       qs5_reg;
    ch_t        rs5_reg, b5_reg;
    wide_t      bqs6_reg;
    logic [2*CH_W-1:0] brs6_reg;
    wide_t      bqs7_reg;
    ch_t        t7_reg;
    wide_t      y8_reg;
    ch_t        soft_reg [SOFT_HOLD];

    div_st_t    dv_reg   [DIV_STAGES];
    div_st_t    dv_next  [DIV_STAGES];
    ch_t        rline_reg[DIV_STAGES];
    sel_t       sline_reg[DIV_STAGES];
    ch_t        res_reg;

    // stage 1 combinational
    logic [CH_W:0]     a2x, b2x, hl_c, ov_c;
    logic              hl_lo, ov_lo;
    ch_t               hl_x, ov_x, mb, ma;
    logic [2*CH_W-1:0] prod_ab, prod_hl, prod_ov;
    logic [2*CH_W:0]   prod_p2;
    logic [2*CH_W-1:0] dn_dodge, dn_burn;
    logic [CH_W+1:0]   sum_ab;
    logic signed [CH_W+3:0] lin_burn;
    ch_t               simp;
    logic              burn_ovr;

    always_comb
    begin
        a2x     = {a1_reg, 1'b0};
        b2x     = {b1_reg, 1'b0};
        hl_c    = a2x - {1'b0, CH_MAX};
        ov_c    = b2x - {1'b0, CH_MAX};
        hl_lo   = (a2x <= {1'b0, CH_MAX});
        ov_lo   = (b2x <= {1'b0, CH_MAX});
        hl_x    = hl_lo ? a2x[CH_W-1:0] : hl_c[CH_W-1:0];
        ov_x    = ov_lo ? b2x[CH_W-1:0] : ov_c[CH_W-1:0];
        mb      = CH_MAX - b1_reg;
        ma      = CH_MAX - a1_reg;
        prod_ab = (2*CH_W)'(a1_reg) * (2*CH_W)'(b1_reg);
        prod_hl = (2*CH_W)'(hl_x) * (2*CH_W)'(b1_reg);
        prod_ov = (2*CH_W)'(ov_x) * (2*CH_W)'(a1_reg);
        prod_p2 = (2*CH_W+1)'(a2x) * (2*CH_W+1)'(mb);
        dn_dodge = {b1_reg, {CH_W{1'b0}}} - {{CH_W{1'b0}}, b1_reg};
        dn_burn  = {mb, {CH_W{1'b0}}} - {{CH_W{1'b0}}, mb}
                 + {{CH_W{1'b0}}, a1_reg} - {{(2*CH_W-1){1'b0}}, 1'b1};
        burn_ovr = (a1_reg == '0) || (mb >= a1_reg);
        sum_ab   = {2'b0, a1_reg} + {2'b0, b1_reg};
        lin_burn = $signed({2'b0, sum_ab}) - $signed({4'b0, CH_MAX});
        case (mode1_reg)
            MODE_DARKEN:     simp = (a1_reg < b1_reg) ? a1_reg : b1_reg;
            MODE_LIGHTEN:    simp = (a1_reg > b1_reg) ? a1_reg : b1_reg;
            MODE_LIN_DODGE:  simp = clamp_ch($signed({2'b0, sum_ab}));
            MODE_LIN_BURN:   simp = clamp_ch(lin_burn);
            MODE_DIFFERENCE: simp = (a1_reg > b1_reg) ? (a1_reg - b1_reg) : (b1_reg - a1_reg);
            default:         simp = a1_reg;
        endcase
    end

    // stage 2 combinational
    quo_t  q_mult, q_hl, q_ov, q_excl;
    ch_t   r_scr, r_hard, r_over, r_excl, res3;
    sel_t  sel3;
    logic  sat;
    logic signed [CH_W+3:0] excl_v;
    wide_t s3;
    div_st_t dinit;

    always_comb
    begin
        q_mult = div_m(ab2_reg);
        q_hl   = div_m(hlp2_reg);
        q_ov   = div_m(ovp2_reg);
        q_excl = div_m({ab2_reg[2*CH_W:0], 1'b0} + wz(CH_MAX) - wide_t'(1));
        r_scr  = screen_ch(a2_reg, b2_reg, ab2_reg);
        r_hard = hl_lo2_reg ? q_hl[CH_W-1:0] : screen_ch(hl_x2_reg, b2_reg, hlp2_reg);
        r_over = ov_lo2_reg ? q_ov[CH_W-1:0] : screen_ch(ov_x2_reg, a2_reg, ovp2_reg);
        excl_v = $signed({4'b0, a2_reg}) + $signed({4'b0, b2_reg}) - $signed({2'b0, q_excl});
        r_excl = clamp_ch(excl_v);
        sat    = (dn2_reg[2*CH_W-1:CH_W] >= dd2_reg);
        s3     = {p1_2_reg[CH_W+1:0], {CH_W{1'b0}}} - p1_2_reg + p2_2_reg;
        dinit.r  = dn2_reg[2*CH_W-1:CH_W];
        dinit.lo = dn2_reg[CH_W-1:0];
        dinit.q  = '0;
        dinit.d  = dd2_reg;
        sel3 = SEL_FIXED;
        case (mode2_reg)
            MODE_MULTIPLY:   res3 = q_mult[CH_W-1:0];
            MODE_SCREEN:     res3 = r_scr;
            MODE_OVERLAY:    res3 = r_over;
            MODE_HARD_LIGHT: res3 = r_hard;
            MODE_EXCLUSION:  res3 = r_excl;
            MODE_DODGE:
            begin
                res3 = CH_MAX;
                if (!(ovr2_reg || sat))
                    sel3 = SEL_QUOT;
            end
            MODE_BURN:
            begin
                res3 = '0;
                if (!ovr2_reg)
                    sel3 = SEL_INV_QUOT;
            end
            MODE_SOFT_LIGHT:
            begin
                res3 = '0;
                sel3 = SEL_SOFT;
            end
            default:         res3 = simp2_reg;
        endcase
    end

    // soft light combinational
    wide_t qsm;
    wide_t rs_full;
    quo_t  t7_q, soft_q;
    ch_t   soft_next;

    always_comb
    begin
        qsm       = {qs4_reg[CH_W+1:0], {CH_W{1'b0}}} - {{CH_W{1'b0}}, qs4_reg};
        rs_full   = s4_reg - qsm;
        t7_q      = div_m({2'b0, brs6_reg});
        soft_q    = div_m(y8_reg);
        soft_next = (soft_q > {2'b0, CH_MAX}) ? CH_MAX : soft_q[CH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= lane_in.func;
            a1_reg    <= lane_in.fg;
            b1_reg    <= lane_in.bg;

            mode2_reg  <= mode1_reg;
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            ab2_reg    <= {2'b0, prod_ab};
            hlp2_reg   <= {2'b0, prod_hl};
            ovp2_reg   <= {2'b0, prod_ov};
            p1_2_reg   <= wz(b1_reg);
            p2_2_reg   <= {1'b0, prod_p2};
            hl_lo2_reg <= hl_lo;
            ov_lo2_reg <= ov_lo;
            hl_x2_reg  <= hl_x;
            ov_x2_reg  <= ov_x;
            dn2_reg    <= (mode1_reg == MODE_BURN) ? dn_burn : dn_dodge;
            dd2_reg    <= (mode1_reg == MODE_BURN) ? a1_reg : ma;
            ovr2_reg   <= (mode1_reg == MODE_BURN) ? burn_ovr : (a1_reg == CH_MAX);
            simp2_reg  <= simp;

            res3_reg   <= res3;
            sel3_reg   <= sel3;
            s3_reg     <= s3;
            b3_reg     <= b2_reg;
            dinit3_reg <= dinit;

            qs4_reg  <= div_m(s3_reg);
            s4_reg   <= s3_reg;
            b4_reg   <= b3_reg;
            qs5_reg  <= qs4_reg;
            rs5_reg  <= rs_full[CH_W-1:0];
            b5_reg   <= b4_reg;
            bqs6_reg <= wide_t'(b5_reg) * wide_t'(qs5_reg);
            brs6_reg <= (2*CH_W)'(b5_reg) * (2*CH_W)'(rs5_reg);
            bqs7_reg <= bqs6_reg;
            t7_reg   <= t7_q[CH_W-1:0];
            y8_reg   <= bqs7_reg + wz(t7_reg);
            soft_reg[0] <= soft_next;
            for (int j = 1; j < SOFT_HOLD; j++)
                soft_reg[j] <= soft_reg[j-1];

            for (int k = 0; k < DIV_STAGES; k++)
                dv_reg[k] <= dv_next[k];
            rline_reg[0] <= res3_reg;
            sline_reg[0] <= sel3_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                rline_reg[k] <= rline_reg[k-1];
                sline_reg[k] <= sline_reg[k-1];
            end

            case (sline_reg[DIV_STAGES-1])
                SEL_QUOT:     res_reg <= dv_reg[DIV_STAGES-1].q;
                SEL_INV_QUOT: res_reg <= CH_MAX - dv_reg[DIV_STAGES-1].q;
                SEL_SOFT:     res_reg <= soft_reg[SOFT_HOLD-1];
                default:      res_reg <= rline_reg[DIV_STAGES-1];
            endcase
        end
    end

    // long division, a few quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        always_comb
        begin
            div_st_t tmp;
            tmp = (k == 0) ? dinit3_reg : dv_reg[(k == 0) ? 0 : k-1];
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                if (k * DIV_STEPS + i < CH_W)
                    tmp = div_step(tmp);
            end
            dv_next[k] = tmp;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

>>> hdl/separable_blend_unit_core.sv
// top level: three channel lanes, valid pipeline and alpha delay line
//
// Blends a foreground and a background RGB pixel channel by channel in one
// of fourteen separable modes selected by func; fg_alpha passes through.
// Input channel: in_valid / in_ready with func, fg_* and bg_* fields.
// Output channel: out_valid / out_ready with out_red, out_green, out_blue
// and out_alpha.
// Each lane holds two operand and product stages, one stage of constant
// divides, then the quotient divider for dodge and burn at two bits per
// stage, then the result register. Throughput is one pixel per cycle while
// the output is not stalled; the three lanes run in lockstep.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a new pixel is accepted in the same cycle that
// a result leaves.
// While the receiver stalls with a result waiting, the pipeline holds and
// in_ready is low; nothing is dropped.
// Reset clears all valid flags; the first pixel may be sent right after.
`default_nettype none
module separable_blend_unit_core
    import sbu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  func,
    input  wire logic [15:0] fg_red,
    input  wire logic [15:0] fg_green,
    input  wire logic [15:0] fg_blue,
    input  wire logic [15:0] fg_alpha,
    input  wire logic [15:0] bg_red,
    input  wire logic [15:0] bg_green,
    input  wire logic [15:0] bg_blue,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_red,
    output logic [15:0]      out_green,
    output logic [15:0]      out_blue,
    output logic [15:0]      out_alpha
);

    logic        vld_reg   [LANE_LAT];
    logic [15:0] alpha_reg [LANE_LAT];
    logic        en;
    lane_in_t    lin_r, lin_g, lin_b;
    ch_t         res_r, res_g, res_b;

    assign en       = !vld_reg[LANE_LAT-1] || out_ready;
    assign in_ready = en;

    assign lin_r = '{func: func, fg: fg_red[CH_W-1:0],   bg: bg_red[CH_W-1:0]};
    assign lin_g = '{func: func, fg: fg_green[CH_W-1:0], bg: bg_green[CH_W-1:0]};
    assign lin_b = '{func: func, fg: fg_blue[CH_W-1:0],  bg: bg_blue[CH_W-1:0]};

    sbu_lane u_lane_r (.clk(clk), .en(en), .lane_in(lin_r), .res(res_r));
    sbu_lane u_lane_g (.clk(clk), .en(en), .lane_in(lin_g), .res(res_g));
    sbu_lane u_lane_b (.clk(clk), .en(en), .lane_in(lin_b), .res(res_b));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANE_LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LANE_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg[0] <= fg_alpha;
            for (int k = 1; k < LANE_LAT; k++)
                alpha_reg[k] <= alpha_reg[k-1];
        end
    end

    // merge the lane results into one output pixel
    assign out_valid = vld_reg[LANE_LAT-1];
    assign out_red   = 16'(res_r);
    assign out_green = 16'(res_g);
    assign out_blue  = 16'(res_b);
    assign out_alpha = alpha_reg[LANE_LAT-1];

endmodule
`default_nettype wire

>>> hdl/sbu_checker.sv
// port-level checks for the blend unit, bound to the top level
`default_nettype none
module sbu_checker
    import sbu_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_red,
    input wire logic [15:0] out_green,
    input wire logic [15:0] out_blue,
    input wire logic [15:0] out_alpha
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
            && $stable(out_blue) && $stable(out_alpha))
        else $error("output changed while stalled");

    // input side only backs up when a result is stuck
    a_ready_rel: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    // a pipeline stall keeps the input side closed in the next cycle too
    a_stall_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> !in_ready || out_ready)
        else $error("input open during stall");

    // blended channels never exceed full scale
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_red <= 16'(CH_MAX)) && (out_green <= 16'(CH_MAX))
            && (out_blue <= 16'(CH_MAX)))
        else $error("channel above full scale");

endmodule

bind separable_blend_unit_core sbu_checker u_sbu_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha)
);
`default_nettype wire
